// ===== hdl/dtf_pkg.sv =====
`timescale 1ns / 1ps
// shared types, constants and the power-of-ten table for the decimal text parser
package dtf_pkg;

   localparam int DTF_FRAC_BITS   = 24;
   localparam int DTF_INT_BITS    = 39;
   localparam int DTF_FRAC_DIGITS = 9;

   localparam int DTF_LIMIT_W = 39;
   localparam int DTF_FRAC_W  = 30;
   localparam int DTF_VALUE_W = 64;

   localparam logic [DTF_LIMIT_W-1:0] DTF_LIMIT_RESET = 39'd2147483647;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0d;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2b;
   localparam logic [7:0] CH_MINUS = 8'h2d;
   localparam logic [7:0] CH_POINT = 8'h2e;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_MALFORMED = 2'd1,
      STATUS_OVER      = 2'd2
   } dtf_status_type;

   typedef enum logic [1:0] {
      PH_START,
      PH_SIGNED,
      PH_INT,
      PH_FRAC
   } dtf_phase_type;

   typedef enum logic [1:0] {
      S_PARSE,
      S_DIVIDE,
      S_FINISH
   } dtf_state_type;

   function automatic logic [DTF_FRAC_W-1:0] dtf_pow10(input logic [3:0] n);
      logic [DTF_FRAC_W-1:0] p;
      case (n)
         4'd0:    p = 30'd1;
         4'd1:    p = 30'd10;
         4'd2:    p = 30'd100;
         4'd3:    p = 30'd1000;
         4'd4:    p = 30'd10000;
         4'd5:    p = 30'd100000;
         4'd6:    p = 30'd1000000;
         4'd7:    p = 30'd10000000;
         4'd8:    p = 30'd100000000;
         4'd9:    p = 30'd1000000000;
         default: p = 30'd1;
      endcase
      return p;
   endfunction

endpackage

// ===== hdl/dtf_req_if.sv =====
`timescale 1ns / 1ps
// character input channel
interface dtf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;

   modport source (output valid, output char_code, input ready);
   modport sink   (input valid, input char_code, output ready);
endinterface

// ===== hdl/dtf_rsp_if.sv =====
`timescale 1ns / 1ps
// parse result channel
interface dtf_rsp_if import dtf_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic [1:0]                    status;
   logic signed [DTF_VALUE_W-1:0] value;

   modport source (output valid, output status, output value, input ready);
   modport sink   (input valid, input status, input value, output ready);
endinterface

// ===== hdl/dtf_csr_if.sv =====
`timescale 1ns / 1ps
// overflow limit write channel
interface dtf_csr_if import dtf_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [DTF_LIMIT_W-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/decimal_text_to_fixed_point_unit.sv =====
`timescale 1ns / 1ps
// decimal numeral text to signed fixed point converter, top level
//
//  channel | dir | payload                        | beat when
//  --------+-----+--------------------------------+---------------------------
//  req_if  | in  | char_code[7:0]                 | valid && ready
//  rsp_if  | out | status[1:0], value[63:0] s     | valid && ready
//  csr_if  | in  | data[38:0] overflow limit      | valid && ready (always ready)
//
//  an ordinary character is accepted in the parse state; the zero terminator of a valid
//  numeral goes through accept, the restoring divider that scales the fraction by
//  10^count at one quotient bit per cycle, then compose; a failed one skips the divider
//  the result sits in an output register, so the next string's characters flow
//  while it waits; only a later compose step stalls on a full output register
//  reset is synchronous active high and restores the default limit 2147483647
module decimal_text_to_fixed_point_unit
   import dtf_pkg::*;
#(
   parameter int FRAC_BITS = DTF_FRAC_BITS
) (
   input  logic         clock,
   input  logic         reset,
   dtf_req_if.sink      req_if,
   dtf_rsp_if.source    rsp_if,
   dtf_csr_if.sink      csr_if
);

   localparam int CNT_W = $clog2(FRAC_BITS);
   localparam int TOT_BITS = (DTF_INT_BITS + FRAC_BITS > 63) ? 63 : DTF_INT_BITS + FRAC_BITS;
   localparam logic [DTF_VALUE_W-1:0] MAX_MAG = (64'd1 << TOT_BITS) - 64'd1;
   localparam logic [DTF_VALUE_W-1:0] MAX_INT = MAX_MAG >> FRAC_BITS;
   localparam int ACC_W = DTF_LIMIT_W + 4;   // room for x10 + 9

   // sequencer and parse state
   dtf_state_type          state_ff, state_in;
   dtf_phase_type          phase_ff, phase_in;
   dtf_status_type         err_ff, err_in;
   dtf_status_type         status_ff, status_in;
   logic                   neg_ff, neg_in;
   logic [DTF_LIMIT_W-1:0] int_ff, int_in;
   logic [DTF_FRAC_W-1:0]  frac_ff, frac_in;    // doubles as divider remainder
   logic [3:0]             count_ff, count_in;
   logic [DTF_LIMIT_W-1:0] mag_ff, mag_in;
   logic [DTF_LIMIT_W-1:0] limit_ff, limit_in;
   logic [FRAC_BITS-1:0]   quot_ff, quot_in;
   logic [CNT_W-1:0]       step_ff, step_in;

   // output register
   logic                          rsp_valid_ff, rsp_valid_in;
   dtf_status_type                rsp_status_ff, rsp_status_in;
   logic signed [DTF_VALUE_W-1:0] rsp_value_ff, rsp_value_in;

   logic                   req_beat;
   logic [7:0]             ch;
   logic                   is_digit, is_space, is_sign, is_point;
   logic [3:0]             digit;
   dtf_status_type         term_status;
   logic                   to_int;
   logic [DTF_LIMIT_W-1:0] acc_sel;
   logic [ACC_W-1:0]       acc_x10, mag_x10;
   logic                   over;
   logic                   number_start, take;
   logic [DTF_FRAC_W:0]    rem2, divisor, diff;
   logic                   fits;
   logic                   out_free;
   logic [DTF_VALUE_W-1:0] int_wide, mag_fix, val_fix;

   assign req_if.ready = (state_ff == S_PARSE);
   assign csr_if.ready = 1'b1;
   assign req_beat     = req_if.valid && req_if.ready;
   assign ch           = req_if.char_code;

   // character classes
   assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
   assign is_space = (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
   assign is_sign  = (ch == CH_PLUS) || (ch == CH_MINUS);
   assign is_point = (ch == CH_POINT);
   assign digit    = 4'(ch - CH_ZERO);

   // status of a string at its terminator: first error wins, no digit and no point is malformed
   always_comb begin
      if (err_ff != STATUS_OK) begin
         term_status = err_ff;
      end else if (phase_ff == PH_START || phase_ff == PH_SIGNED) begin
         term_status = STATUS_MALFORMED;
      end else begin
         term_status = STATUS_OK;
      end
   end

   // shared x10 + digit unit: integer accumulator before the point, fraction after
   assign to_int  = (phase_ff != PH_FRAC);
   assign acc_sel = to_int ? int_ff : {{(DTF_LIMIT_W-DTF_FRAC_W){1'b0}}, frac_ff};
   assign acc_x10 = ({4'b0, acc_sel} << 3) + ({4'b0, acc_sel} << 1)
                    + {{(ACC_W-4){1'b0}}, digit};
   // all digits as one integer, for the limit check
   assign mag_x10 = ({4'b0, mag_ff} << 3) + ({4'b0, mag_ff} << 1)
                    + {{(ACC_W-4){1'b0}}, digit};
   assign over    = mag_x10 > {4'b0, limit_ff};

   // restoring divider step: remainder stays below 10^count
   assign rem2    = {frac_ff, 1'b0};
   assign divisor = {1'b0, dtf_pow10(count_ff)};
   assign fits    = rem2 >= divisor;
   assign diff    = rem2 - divisor;

   // compose: saturate the integer part, then append the quotient bits
   assign out_free = !rsp_valid_ff || rsp_if.ready;
   assign int_wide = {{(DTF_VALUE_W-DTF_LIMIT_W){1'b0}}, int_ff};
   assign mag_fix  = (int_wide > MAX_INT) ? MAX_MAG
                   : (int_wide << FRAC_BITS) + {{(DTF_VALUE_W-FRAC_BITS){1'b0}}, quot_ff};
   assign val_fix  = neg_ff ? (64'd0 - mag_fix) : mag_fix;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_PARSE: begin
            if (req_beat && ch == CH_NUL) begin
               state_in = (term_status == STATUS_OK) ? S_DIVIDE : S_FINISH;
            end
         end
         S_DIVIDE: begin
            if (step_ff == '0) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (out_free) begin
               state_in = S_PARSE;
            end
         end
         default: state_in = S_PARSE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      phase_in      = phase_ff;
      err_in        = err_ff;
      status_in     = status_ff;
      neg_in        = neg_ff;
      int_in        = int_ff;
      frac_in       = frac_ff;
      count_in      = count_ff;
      mag_in        = mag_ff;
      quot_in       = quot_ff;
      step_in       = step_ff;
      limit_in      = limit_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      number_start  = 1'b0;
      take          = 1'b0;

      if (csr_if.valid) begin
         limit_in = csr_if.data;
      end
      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_PARSE: begin
            if (req_beat && ch == CH_NUL) begin
               status_in = term_status;
               quot_in   = '0;
               step_in   = CNT_W'(FRAC_BITS - 1);
            end else if (req_beat && err_ff == STATUS_OK) begin
               unique case (phase_ff)
                  PH_START: begin
                     if (is_sign) begin
                        neg_in   = (ch == CH_MINUS);
                        phase_in = PH_SIGNED;
                     end else if (!is_space) begin
                        number_start = 1'b1;
                     end
                  end
                  PH_SIGNED: number_start = 1'b1;
                  PH_INT: begin
                     if (is_point) begin
                        phase_in = PH_FRAC;
                     end else if (is_digit) begin
                        take = 1'b1;
                     end else begin
                        err_in = STATUS_MALFORMED;
                     end
                  end
                  PH_FRAC: begin
                     if (is_digit) begin
                        take = 1'b1;
                     end else begin
                        err_in = STATUS_MALFORMED;
                     end
                  end
                  default: err_in = STATUS_MALFORMED;
               endcase

               // first character of the number proper, a leading point included
               if (number_start) begin
                  if (is_point) begin
                     phase_in = PH_FRAC;
                  end else if (is_digit) begin
                     phase_in = PH_INT;
                     take     = 1'b1;
                  end else begin
                     err_in = STATUS_MALFORMED;
                  end
               end

               if (take) begin
                  if (over) begin
                     err_in = STATUS_OVER;
                  end else begin
                     mag_in = mag_x10[DTF_LIMIT_W-1:0];
                     if (to_int) begin
                        int_in = acc_x10[DTF_LIMIT_W-1:0];
                     end else if (count_ff < 4'(DTF_FRAC_DIGITS)) begin
                        // extra fraction digits only feed the limit check
                        frac_in  = acc_x10[DTF_FRAC_W-1:0];
                        count_in = count_ff + 4'd1;
                     end
                  end
               end
            end
         end
         S_DIVIDE: begin
            frac_in = fits ? diff[DTF_FRAC_W-1:0] : rem2[DTF_FRAC_W-1:0];
            quot_in = {quot_ff[FRAC_BITS-2:0], fits};
            step_in = step_ff - CNT_W'(1);
         end
         S_FINISH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_value_in  = (status_ff == STATUS_OK) ? val_fix : '0;
               // ready for the next string
               phase_in = PH_START;
               err_in   = STATUS_OK;
               neg_in   = 1'b0;
               int_in   = '0;
               frac_in  = '0;
               count_in = '0;
               mag_in   = '0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_PARSE;
         phase_ff     <= PH_START;
         err_ff       <= STATUS_OK;
         status_ff    <= STATUS_OK;
         neg_ff       <= 1'b0;
         int_ff       <= '0;
         frac_ff      <= '0;
         count_ff     <= '0;
         mag_ff       <= '0;
         step_ff      <= '0;
         limit_ff     <= DTF_LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         err_ff       <= err_in;
         status_ff    <= status_in;
         neg_ff       <= neg_in;
         int_ff       <= int_in;
         frac_ff      <= frac_in;
         count_ff     <= count_in;
         mag_ff       <= mag_in;
         step_ff      <= step_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      quot_ff       <= quot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
   end

   assign rsp_if.valid  = rsp_valid_ff;
   assign rsp_if.status = rsp_status_ff;
   assign rsp_if.value  = rsp_value_ff;

   // a failed numeral always reports zero
   a_error_value_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.status != STATUS_OK) |-> (rsp_if.value == '0))
      else $error("nonzero value with error status");

   // divider remainder stays below the power of ten
   a_remainder_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIVIDE) |-> ({1'b0, frac_ff} < divisor))
      else $error("divider remainder out of range");

   // a terminator beat always leaves the parse state
   a_terminator_leaves: assert property (@(posedge clock) disable iff (reset)
      (req_beat && ch == CH_NUL) |=> (state_ff != S_PARSE))
      else $error("terminator did not start result");

endmodule
